// ===== design/scu_pkg.sv =====
// ----------------------------------------------------------------------------
// scu_pkg : shared types, constants and functions of the sine/cosine/tangent
// unit. Holds the range reduction constants, the polynomial coefficients and
// the fixed point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package scu_pkg;

   // Reduction works on Q.52 angles held in 62 bits.
   localparam int ANG_W = 62;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   localparam logic [ANG_W-1:0] PI_Q52      = ANG_W'((PI_Q60 + 64'd128) >> 8);
   localparam logic [ANG_W-1:0] TWO_PI_Q52  = ANG_W'((PI_Q60 + 64'd64) >> 7);
   localparam logic [ANG_W-1:0] HALF_PI_Q52 = ANG_W'((PI_Q60 + 64'd256) >> 9);

   // Polynomial values are carried as signed 36-bit Q30.
   localparam int POLY_W = 36;

   localparam longint ONE_L = longint'(1) << 30;

   localparam logic signed [POLY_W-1:0] ONE_Q30 = POLY_W'(ONE_L);
   localparam logic signed [POLY_W-1:0] C3_Q30  = POLY_W'((ONE_L + 3) / 6);
   localparam logic signed [POLY_W-1:0] C5_Q30  = POLY_W'((ONE_L + 60) / 120);
   localparam logic signed [POLY_W-1:0] C7_Q30  = POLY_W'((ONE_L + 2520) / 5040);
   localparam logic signed [POLY_W-1:0] C9_Q30  = POLY_W'((ONE_L + 181440) / 362880);

   // Divider: quotient bits and bits retired per pipeline stage.
   localparam int QUO_W      = 33;
   localparam int DIV_BITS   = 3;
   localparam int DIV_STAGES = QUO_W / DIV_BITS;

   typedef struct packed {
      logic               valid;
      logic               neg;
      logic               zero;
      logic               ovf;
      logic [31:0]        rem;
      logic [QUO_W-1:0]   num;
      logic [QUO_W-1:0]   quo;
      logic [31:0]        den;
      logic signed [31:0] sine;
      logic signed [31:0] cosine;
   } div_stage_type;

   // Q30 x Q30 -> Q30, magnitude rounded half away from zero.
   function automatic logic signed [POLY_W-1:0] mul_q30(
      input logic signed [POLY_W-1:0] a,
      input logic signed [POLY_W-1:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] prod;
      logic [63:0] sum;
      logic [33:0] m;
      ma   = a[POLY_W-1] ? 32'(-a) : a[31:0];
      mb   = b[POLY_W-1] ? 32'(-b) : b[31:0];
      prod = {32'd0, ma} * {32'd0, mb};
      sum  = prod + (64'd1 << 29);
      m    = sum[63:30];
      if (a[POLY_W-1] ^ b[POLY_W-1])
         return -$signed({2'b00, m});
      return $signed({2'b00, m});
   endfunction

   // DIV_BITS steps of restoring division.
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [31:0]   rs;
      r = s;
      for (int i = 0; i < DIV_BITS; i++) begin
         rs = {r.rem[30:0], r.num[QUO_W-1]};
         r.num = {r.num[QUO_W-2:0], 1'b0};
         if (rs >= r.den) begin
            r.rem = rs - r.den;
            r.quo = {r.quo[QUO_W-2:0], 1'b1};
         end else begin
            r.rem = rs;
            r.quo = {r.quo[QUO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/scu_sine_pipe.sv =====
// ----------------------------------------------------------------------------
// scu_sine_pipe : sine of a Q.52 angle
// Range reduction over five stages, then Horner evaluation of the Taylor
// polynomial to x^9 with one multiplier per stage. Result in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module scu_sine_pipe
   import scu_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic signed [ANG_W-1:0] in_angle,
   output logic                         out_valid,
   output logic signed [31:0]           out_sine
);

   localparam logic [ANG_W-1:0] D16 = TWO_PI_Q52 << 4;
   localparam logic [ANG_W-1:0] D8  = TWO_PI_Q52 << 3;
   localparam logic [ANG_W-1:0] D4  = TWO_PI_Q52 << 2;
   localparam logic [ANG_W-1:0] D2  = TWO_PI_Q52 << 1;

   // valid line, one bit per stage
   logic [10:0] vld_ff, vld_in;

   // reduction stages
   logic             neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [ANG_W-1:0] mag1_ff, mag1_in, mag2_ff, mag2_in, mag3_ff, mag3_in;
   logic [ANG_W-1:0] mag4_ff, mag4_in;
   logic             neg4_in;

   // t = folded angle, sign and magnitude in Q30
   logic        tneg5_ff, tneg6_ff, tneg7_ff, tneg8_ff, tneg9_ff, tneg10_ff;
   logic [31:0] tm5_ff, tm5_in, tm6_ff, tm7_ff, tm8_ff, tm9_ff, tm10_ff;
   logic [31:0] t2_6_ff, t2_6_in, t2_7_ff, t2_8_ff, t2_9_ff;

   logic signed [POLY_W-1:0] p7_ff, p7_in, p8_ff, p8_in, p9_ff, p9_in;
   logic signed [POLY_W-1:0] p10_ff, p10_in, s11_ff, s11_in;
   logic signed [POLY_W-1:0] t10_s;

   always_comb begin
      vld_in = {vld_ff[9:0], in_valid};
   end

   always_comb begin
      mag1_in = in_angle[ANG_W-1] ? ANG_W'(-in_angle) : in_angle;
   end

   always_comb begin
      logic [ANG_W-1:0] m;
      m = mag1_ff;
      if (m >= D16) m = m - D16;
      if (m >= D8)  m = m - D8;
      mag2_in = m;
   end

   always_comb begin
      logic [ANG_W-1:0] m;
      m = mag2_ff;
      if (m >= D4) m = m - D4;
      if (m >= D2) m = m - D2;
      mag3_in = m;
   end

   // last turn removed, then wrap into [-pi, pi]
   always_comb begin
      logic [ANG_W-1:0] m;
      m = mag3_ff;
      if (m >= TWO_PI_Q52) m = m - TWO_PI_Q52;
      if (m > PI_Q52) begin
         mag4_in = TWO_PI_Q52 - m;
         neg4_in = ~neg3_ff;
      end else begin
         mag4_in = m;
         neg4_in = neg3_ff;
      end
   end

   // fold into [-pi/2, pi/2], round to Q30
   always_comb begin
      logic [ANG_W-1:0] u;
      logic [ANG_W-1:0] ur;
      u  = (mag4_ff > HALF_PI_Q52) ? (PI_Q52 - mag4_ff) : mag4_ff;
      ur = (u + (ANG_W'(1) << 21)) >> 22;
      tm5_in = ur[31:0];
   end

   always_comb begin
      logic signed [POLY_W-1:0] t2;
      t2      = mul_q30($signed({4'd0, tm5_ff}), $signed({4'd0, tm5_ff}));
      t2_6_in = t2[31:0];
   end

   always_comb begin
      p7_in  = C7_Q30 - mul_q30($signed({4'd0, t2_6_ff}), C9_Q30);
      p8_in  = C5_Q30 - mul_q30($signed({4'd0, t2_7_ff}), p7_ff);
      p9_in  = C3_Q30 - mul_q30($signed({4'd0, t2_8_ff}), p8_ff);
      p10_in = ONE_Q30 - mul_q30($signed({4'd0, t2_9_ff}), p9_ff);
      t10_s  = tneg10_ff ? -$signed({4'd0, tm10_ff}) : $signed({4'd0, tm10_ff});
      s11_in = mul_q30(t10_s, p10_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff   <= in_angle[ANG_W-1];
      mag1_ff   <= mag1_in;
      neg2_ff   <= neg1_ff;
      mag2_ff   <= mag2_in;
      neg3_ff   <= neg2_ff;
      mag3_ff   <= mag3_in;
      neg4_ff   <= neg4_in;
      mag4_ff   <= mag4_in;
      tneg5_ff  <= neg4_ff;
      tm5_ff    <= tm5_in;
      tneg6_ff  <= tneg5_ff;
      tm6_ff    <= tm5_ff;
      t2_6_ff   <= t2_6_in;
      tneg7_ff  <= tneg6_ff;
      tm7_ff    <= tm6_ff;
      t2_7_ff   <= t2_6_ff;
      p7_ff     <= p7_in;
      tneg8_ff  <= tneg7_ff;
      tm8_ff    <= tm7_ff;
      t2_8_ff   <= t2_7_ff;
      p8_ff     <= p8_in;
      tneg9_ff  <= tneg8_ff;
      tm9_ff    <= tm8_ff;
      t2_9_ff   <= t2_8_ff;
      p9_ff     <= p9_in;
      tneg10_ff <= tneg9_ff;
      tm10_ff   <= tm9_ff;
      p10_ff    <= p10_in;
      s11_ff    <= s11_in;
   end

   assign out_valid = vld_ff[10];
   assign out_sine  = s11_ff[31:0];

endmodule

`default_nettype wire

// ===== design/scu_tan_div.sv =====
// ----------------------------------------------------------------------------
// scu_tan_div : tangent from sine and cosine
// Pipelined restoring divider, a few quotient bits per stage, with rounding,
// saturation and the cosine-zero case. Passes sine and cosine along.
// ----------------------------------------------------------------------------
`default_nettype none

module scu_tan_div
   import scu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] in_sine,
   input  wire logic signed [31:0] in_cosine,
   output logic                    out_valid,
   output logic signed [31:0]      out_sine,
   output logic signed [31:0]      out_cosine,
   output logic signed [31:0]      out_tangent,
   output logic                    out_undefined
);

   div_stage_type stage_ff [DIV_STAGES+1];
   div_stage_type stage_in [DIV_STAGES+1];

   logic               vld_ff;
   logic signed [31:0] sine_ff, cosine_ff, tan_ff, tan_in;
   logic               undef_ff;

   // numerator = |s|<<16 + |c|/2; top bits seed the remainder
   always_comb begin
      logic [31:0] ms;
      logic [31:0] mc;
      logic [47:0] n;
      ms = in_sine[31]   ? 32'(-in_sine)   : in_sine;
      mc = in_cosine[31] ? 32'(-in_cosine) : in_cosine;
      n  = {ms, 16'd0} + 48'(mc[31:1]);
      stage_in[0].valid  = in_valid;
      stage_in[0].neg    = in_sine[31] ^ in_cosine[31];
      stage_in[0].zero   = (in_cosine == 32'sd0);
      stage_in[0].ovf    = 32'(n[47:QUO_W]) >= mc;
      stage_in[0].rem    = 32'(n[47:QUO_W]);
      stage_in[0].num    = n[QUO_W-1:0];
      stage_in[0].quo    = '0;
      stage_in[0].den    = mc;
      stage_in[0].sine   = in_sine;
      stage_in[0].cosine = in_cosine;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      always_comb begin
         stage_in[k+1] = div_step(stage_ff[k]);
      end
   end

   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_reg
      always_ff @(posedge clock) begin
         div_stage_type nxt;
         nxt = stage_in[k];
         if (reset) begin
            nxt.valid = 1'b0;
         end
         stage_ff[k] <= nxt;
      end
   end

   always_comb begin
      div_stage_type    f;
      logic [QUO_W-1:0] q;
      logic [QUO_W-1:0] lim;
      logic [QUO_W-1:0] tq;
      f   = stage_ff[DIV_STAGES];
      lim = f.neg ? QUO_W'(33'h080000000) : QUO_W'(33'h07FFFFFFF);
      q   = (f.ovf || f.quo > lim) ? lim : f.quo;
      tq  = f.neg ? -q : q;
      tan_in = f.zero ? 32'sd0 : $signed(tq[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= stage_ff[DIV_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      sine_ff   <= stage_ff[DIV_STAGES].sine;
      cosine_ff <= stage_ff[DIV_STAGES].cosine;
      tan_ff    <= tan_in;
      undef_ff  <= stage_ff[DIV_STAGES].zero;
   end

   assign out_valid     = vld_ff;
   assign out_sine      = sine_ff;
   assign out_cosine    = cosine_ff;
   assign out_tangent   = tan_ff;
   assign out_undefined = undef_ff;

endmodule

`default_nettype wire

// ===== design/sine_cosine_tangent_unit.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_tangent_unit : sine, cosine and tangent of a Q8.24 angle
// An accepted word passes the input register, the sine and cosine pipes and the divider before the rsp_valid strobe.
// Throughput one word per cycle; busy is never raised, results cannot stall.
// Sine and cosine paths run side by side, tangent follows in a pipelined
// divider. Synchronous reset clears only the valid line.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_tangent_unit
   import scu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_angle,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_sine_value,
   output logic signed [31:0]      rsp_cosine_value,
   output logic signed [31:0]      rsp_tangent_value,
   output logic                    rsp_tangent_undefined
);

   logic               vld_ff;
   logic signed [31:0] angle_ff;

   logic signed [ANG_W-1:0] x_sin, x_cos;
   logic                    sin_vld, cos_vld;
   logic signed [31:0]      sin_val, cos_val;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= req_angle;
   end

   // Q8.24 -> Q.52; cosine is sine of angle + pi/2
   assign x_sin = $signed({{2{angle_ff[31]}}, angle_ff, 28'd0});
   assign x_cos = x_sin + $signed(HALF_PI_Q52);

   scu_sine_pipe u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff),
      .in_angle  (x_sin),
      .out_valid (sin_vld),
      .out_sine  (sin_val)
   );

   scu_sine_pipe u_cosine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff),
      .in_angle  (x_cos),
      .out_valid (cos_vld),
      .out_sine  (cos_val)
   );

   scu_tan_div u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sin_vld & cos_vld),
      .in_sine       (sin_val),
      .in_cosine     (cos_val),
      .out_valid     (rsp_valid),
      .out_sine      (rsp_sine_value),
      .out_cosine    (rsp_cosine_value),
      .out_tangent   (rsp_tangent_value),
      .out_undefined (rsp_tangent_undefined)
   );

endmodule

`default_nettype wire

// ===== dv/sine_cosine_tangent_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_tangent_unit_tb : self-checking bench for the trig unit
// Random and directed angles go in through start/busy. Every strobed result
// is checked against an in-bench fixed point predictor of sine, cosine,
// tangent and the undefined flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_tangent_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] sine;
      logic signed [31:0] cosine;
      logic signed [31:0] tangent;
      logic               undef;
   } trig_word_type;

   localparam longint PI60   = 64'h3243F6A8885A308D;
   localparam longint PI52   = (PI60 + 128) >>> 8;
   localparam longint TWOPI  = (PI60 + 64) >>> 7;
   localparam longint HALFPI = (PI60 + 256) >>> 9;
   localparam longint ONE30  = longint'(1) << 30;
   localparam longint K3     = (ONE30 + 3) / 6;
   localparam longint K5     = (ONE30 + 60) / 120;
   localparam longint K7     = (ONE30 + 2520) / 5040;
   localparam longint K9     = (ONE30 + 181440) / 362880;
   localparam int     LATENCY = 24;
   localparam int     WATCHDOG = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic signed [31:0] req_angle = '0;
   logic               busy;
   logic               rsp_valid;
   logic signed [31:0] rsp_sine_value;
   logic signed [31:0] rsp_cosine_value;
   logic signed [31:0] rsp_tangent_value;
   logic               rsp_tangent_undefined;

   logic signed [31:0] angle_queue[$];
   trig_word_type      expected_words[$];
   int                 errors = 0;
   int                 wait_cycles = 0;
   int                 idle_count = 0;
   bit                 hold_off = 0;

   sine_cosine_tangent_unit dut (.*);

   always #4 clock = ~clock;

   function automatic longint round_shift(longint v, int n);
      longint m;
      m = ((v < 0 ? -v : v) + (longint'(1) << (n - 1))) >>> n;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint m;
      m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (longint'(1) << 29)) >>> 30;
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic longint taylor_sine(longint x);
      longint r, t, t2, p;
      r = x - (x / TWOPI) * TWOPI;
      if (r > PI52) r -= TWOPI;
      if (r < -PI52) r += TWOPI;
      if (r > HALFPI) r = PI52 - r;
      else if (r < -HALFPI) r = -PI52 - r;
      t  = round_shift(r, 22);
      t2 = fx_mul(t, t);
      p  = K7 - fx_mul(t2, K9);
      p  = K5 - fx_mul(t2, p);
      p  = K3 - fx_mul(t2, p);
      p  = ONE30 - fx_mul(t2, p);
      return fx_mul(t, p);
   endfunction

   function automatic trig_word_type predict_trig(logic signed [31:0] ang);
      trig_word_type w;
      longint x, s, c, ms, mc, q;
      bit neg;
      x = longint'(ang) * (longint'(1) << 28);
      s = taylor_sine(x);
      c = taylor_sine(x + HALFPI);
      w.sine = 32'(s);
      w.cosine = 32'(c);
      w.undef = (c == 0);
      w.tangent = '0;
      if (c != 0) begin
         ms = s < 0 ? -s : s;
         mc = c < 0 ? -c : c;
         q = ((ms << 16) + (mc >>> 1)) / mc;
         neg = (s < 0) != (c < 0);
         if (neg && q > 64'h80000000) q = 64'h80000000;
         if (!neg && q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
         w.tangent = 32'(neg ? -q : q);
      end
      return w;
   endfunction

   // driver: one word per handshake, random gap after each
   always @(negedge clock) begin
      if (reset || hold_off) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (wait_cycles > 0) begin
         wait_cycles <= wait_cycles - 1;
         start <= 1'b0;
      end else if (angle_queue.size() > 0) begin
         req_angle <= angle_queue.pop_front();
         start <= 1'b1;
         wait_cycles <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      trig_word_type w;
      bit            active;
      active = 1'b0;
      if (!reset && start && !busy) begin
         expected_words.push_back(predict_trig(req_angle));
         active = 1'b1;
      end
      if (!reset && rsp_valid) begin
         active = 1'b1;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word sin=%h", $time, rsp_sine_value);
            errors++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_sine_value !== w.sine)
               $display("%0t: sine exp %h act %h", $time, w.sine, rsp_sine_value);
            if (rsp_cosine_value !== w.cosine)
               $display("%0t: cosine exp %h act %h", $time, w.cosine, rsp_cosine_value);
            if (rsp_tangent_value !== w.tangent)
               $display("%0t: tangent exp %h act %h", $time, w.tangent,
                        rsp_tangent_value);
            if (rsp_tangent_undefined !== w.undef)
               $display("%0t: undefined exp %b act %b", $time, w.undef,
                        rsp_tangent_undefined);
            if (rsp_sine_value !== w.sine || rsp_cosine_value !== w.cosine ||
                rsp_tangent_value !== w.tangent || rsp_tangent_undefined !== w.undef)
               errors++;
         end
      end
      idle_count <= active ? 0 : idle_count + 1;
      if (idle_count >= WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic add_angles(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 3);
         case (sel)
            0: angle_queue.push_back($urandom);
            // small angles within +-4, and angles near multiples of pi/2 up to +-3pi
            1: angle_queue.push_back($signed(32'($urandom_range(0, 32'h0800_0000))) -
                                     32'sh0400_0000);
            2: angle_queue.push_back((($urandom_range(0, 1) ? 1 : -1) *
                                      ($urandom_range(1, 6) * 32'sh0192_2000)) +
                                     $signed(32'($urandom_range(0, 512))) - 256);
            default: angle_queue.push_back($signed(32'($urandom_range(0, 32'h3000_0000))) -
                                           32'sh1800_0000);
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, zero, multiples of pi/2 and 2pi
      angle_queue = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1, -32'sh1,
                      32'sh0192_1FB5, -32'sh0192_1FB5, 32'sh0324_3F6A,
                      -32'sh0324_3F6A, 32'sh0648_7ED5, -32'sh0648_7ED5,
                      32'sh04B6_5F1F, 32'sh0192_1FB4, 32'sh0192_1FB6,
                      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0100_0000,
                      -32'sh0100_0000, 32'sh7F00_0000};
      add_angles(450);
      wait (angle_queue.size() == 0);
      // let the pipe drain completely before resuming
      @(negedge clock);
      hold_off = 1;
      wait (expected_words.size() == 0);
      hold_off = 0;
      add_angles(450);
      wait (angle_queue.size() == 0);
      @(posedge clock);
      wait (expected_words.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
